FILE: rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types, result codes and the CRC-32 byte table for the chunk deframer.
// ----------------------------------------------------------------------------
package csd_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_CHECK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_ZERO = 2'd1;

	typedef logic [31:0] crc_table_t [256];

	function automatic crc_table_t crc_gen_table();
		crc_table_t  t;
		logic [31:0] c;
		for (int i = 0; i < 256; i++) begin
			c = 32'(i);
			for (int j = 0; j < 8; j++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
			t[i] = c;
		end
		return t;
	endfunction

	localparam crc_table_t CRC_TABLE = crc_gen_table();

	// reflected CRC-32, one byte per call via table
	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		crc_step = (crc >> 8) ^ CRC_TABLE[crc[7:0] ^ b];
	endfunction

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_END   = 2'd1,
		KIND_STOP  = 2'd2,
		KIND_TRUNC = 2'd3
	} kind_t;

	typedef struct packed {
		logic crc_check_enable;
		logic stop_on_zero_type;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [31:0] chunk_type;
		logic [31:0] chunk_length;
		logic        crc_ok;
		logic [31:0] crc_received;
	} result_t;

endpackage

FILE: rtl/csd_parser.sv
// ----------------------------------------------------------------------------
// csd_parser
// Chunk framing state and running CRC; decodes one byte per accepted beat.
// ----------------------------------------------------------------------------
module csd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        byte_in,
	input  logic              stream_start,
	input  logic              last_byte,
	input  csd_pkg::cfg_t     cfg,
	output logic              res_valid,
	output csd_pkg::result_t  res
);
	import csd_pkg::*;

	typedef enum logic [3:0] {
		PH_LEN  = 4'b0001,
		PH_TYPE = 4'b0010,
		PH_DATA = 4'b0100,
		PH_CRC  = 4'b1000
	} phase_t;

	phase_t      phase_q,   phase_d;
	logic [31:0] cnt_q,     cnt_d;
	logic [31:0] len_q,     len_d;
	logic [31:0] type_q,    type_d;
	logic [31:0] crc_q,     crc_d;
	logic [31:0] crcrd_q,   crcrd_d;
	logic        stopped_q, stopped_d;

	phase_t      ph;
	logic [31:0] cnt, len, typ, crc, crcrd;
	logic        stp, ended;
	logic [31:0] cnt_inc, crc_nx;

	always_comb begin
		ph    = stream_start ? PH_LEN : phase_q;
		cnt   = stream_start ? 32'd0 : cnt_q;
		len   = stream_start ? 32'd0 : len_q;
		typ   = stream_start ? 32'd0 : type_q;
		crc   = stream_start ? CRC_INIT : crc_q;
		crcrd = stream_start ? 32'd0 : crcrd_q;
		stp   = stream_start ? 1'b0 : stopped_q;

		cnt_inc = cnt + 32'd1;
		crc_nx  = crc_step(crc, byte_in);

		phase_d   = ph;
		cnt_d     = cnt;
		len_d     = len;
		type_d    = typ;
		crc_d     = crc;
		crcrd_d   = crcrd;
		stopped_d = stp;
		ended     = 1'b0;

		res_valid        = 1'b0;
		res.kind         = KIND_DATA;
		res.data_byte    = 8'd0;
		res.chunk_type   = 32'd0;
		res.chunk_length = 32'd0;
		res.crc_ok       = 1'b0;
		res.crc_received = 32'd0;

		if (!stp) begin
			case (ph)
				PH_LEN: begin
					len_d = {len[23:0], byte_in};
					cnt_d = cnt_inc;
					if (cnt[1:0] == 2'd3) begin
						phase_d = PH_TYPE;
						cnt_d   = 32'd0;
					end
				end
				PH_TYPE: begin
					case (cnt[1:0])
						2'd0:    type_d = typ | {24'd0, byte_in};
						2'd1:    type_d = typ | {16'd0, byte_in, 8'd0};
						2'd2:    type_d = typ | {8'd0, byte_in, 16'd0};
						default: type_d = typ | {byte_in, 24'd0};
					endcase
					crc_d = crc_nx;
					cnt_d = cnt_inc;
					if (cnt[1:0] == 2'd3) begin
						cnt_d = 32'd0;
						if (cfg.stop_on_zero_type && type_d == 32'd0) begin
							res_valid        = 1'b1;
							res.kind         = KIND_STOP;
							res.chunk_type   = type_d;
							res.chunk_length = len;
							stopped_d        = 1'b1;
							ended            = 1'b1;
						end else begin
							phase_d = (len == 32'd0) ? PH_CRC : PH_DATA;
						end
					end
				end
				PH_DATA: begin
					crc_d            = crc_nx;
					res_valid        = 1'b1;
					res.kind         = KIND_DATA;
					res.data_byte    = byte_in;
					res.chunk_type   = typ;
					res.chunk_length = len;
					cnt_d            = cnt_inc;
					if (cnt_inc == len) begin
						phase_d = PH_CRC;
						cnt_d   = 32'd0;
					end
				end
				default: begin
					crcrd_d = {crcrd[23:0], byte_in};
					cnt_d   = cnt_inc;
					if (cnt[1:0] == 2'd3) begin
						res_valid        = 1'b1;
						res.kind         = KIND_END;
						res.chunk_type   = typ;
						res.chunk_length = len;
						res.crc_ok       = cfg.crc_check_enable ? (crcrd_d == ~crc) : 1'b1;
						res.crc_received = crcrd_d;
						ended            = 1'b1;
						phase_d          = PH_LEN;
						cnt_d            = 32'd0;
						len_d            = 32'd0;
						type_d           = 32'd0;
						crc_d            = CRC_INIT;
						crcrd_d          = 32'd0;
					end
				end
			endcase

			if (last_byte) begin
				if (!ended) begin
					res_valid        = 1'b1;
					res.kind         = KIND_TRUNC;
					res.data_byte    = 8'd0;
					res.chunk_type   = type_d;
					res.chunk_length = len_d;
					res.crc_ok       = 1'b0;
					res.crc_received = crcrd_d;
				end
				stopped_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEN;
			cnt_q     <= 32'd0;
			len_q     <= 32'd0;
			type_q    <= 32'd0;
			crc_q     <= CRC_INIT;
			crcrd_q   <= 32'd0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			len_q     <= len_d;
			type_q    <= type_d;
			crc_q     <= crc_d;
			crcrd_q   <= crcrd_d;
			stopped_q <= stopped_d;
		end
	end

endmodule

FILE: rtl/csd_obuf.sv
// ----------------------------------------------------------------------------
// csd_obuf
// Two-entry result buffer; keeps the input side moving while a beat waits.
// ----------------------------------------------------------------------------
module csd_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csd_pkg::result_t  push_data,
	input  logic              pop,
	output logic              valid,
	output logic              full,
	output csd_pkg::result_t  head
);
	import csd_pkg::*;

	result_t    ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign valid = (count_q != 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: rtl/chunk_stream_deframer_crc_check.sv
// ----------------------------------------------------------------------------
// chunk_stream_deframer_crc_check
// Splits a byte stream into length/type/data/CRC chunks and checks CRC-32.
// ----------------------------------------------------------------------------
// One byte is taken per beat and one beat per clock is sustained while the
// result buffer is not full: the framing counters and a table-driven CRC-32
// byte step update on each accepted beat, and at most one result beat follows
// each input beat, registered in a two-entry buffer, so input is stalled only
// when two result beats are waiting. Config writes are always ready.
module chunk_stream_deframer_crc_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [7:0]                       byte_in,
	input  logic                             stream_start,
	input  logic                             last_byte,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [1:0]                       kind,
	output logic [7:0]                       data_byte,
	output logic [31:0]                      chunk_type,
	output logic [31:0]                      chunk_length,
	output logic                             crc_ok,
	output logic [31:0]                      crc_received,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [csd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic                             cfg_data
);
	import csd_pkg::*;

	cfg_t    cfg_q;
	logic    accept, full, res_valid, pop;
	result_t res, head;

	assign cfg_ready  = 1'b1;
	assign item_stall = full;
	assign accept     = item_valid && !item_stall;
	assign pop        = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_check_enable  <= 1'b1;
			cfg_q.stop_on_zero_type <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CRC_CHECK: cfg_q.crc_check_enable  <= cfg_data;
				CFG_STOP_ZERO: cfg_q.stop_on_zero_type <= cfg_data;
				default: ;
			endcase
		end
	end

	csd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.byte_in      (byte_in),
		.stream_start (stream_start),
		.last_byte    (last_byte),
		.cfg          (cfg_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	csd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.pop       (pop),
		.valid     (result_valid),
		.full      (full),
		.head      (head)
	);

	assign kind         = head.kind;
	assign data_byte    = head.data_byte;
	assign chunk_type   = head.chunk_type;
	assign chunk_length = head.chunk_length;
	assign crc_ok       = head.crc_ok;
	assign crc_received = head.crc_received;

endmodule

FILE: rtl/csd_checker.sv
// ----------------------------------------------------------------------------
// csd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module csd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  kind,
	input logic [7:0]  data_byte,
	input logic [31:0] chunk_type,
	input logic        crc_ok,
	input logic [31:0] crc_received
);
	import csd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(kind)
			&& $stable(crc_received))
		else $error("result beat dropped or changed while stalled");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_DATA |-> !crc_ok && crc_received == 32'd0)
		else $error("data beat carries CRC fields");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != KIND_DATA |-> data_byte == 8'd0)
		else $error("non-data beat carries a byte");

	a_stop_type: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_STOP |-> chunk_type == 32'd0 && !crc_ok)
		else $error("stream end with nonzero type");

endmodule

bind chunk_stream_deframer_crc_check csd_checker u_csd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.kind         (kind),
	.data_byte    (data_byte),
	.chunk_type   (chunk_type),
	.crc_ok       (crc_ok),
	.crc_received (crc_received)
);
